FILE: hdl/lr_pkg.sv
// Shared constants for the line rasterizer: line classes, opcodes, register map.
package lr_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int DIM_BITS       = 11;
  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_ADDR_BITS  = 3;

  localparam logic [DIM_BITS-1:0] WIDTH_RST  = 11'd800;
  localparam logic [DIM_BITS-1:0] HEIGHT_RST = 11'd600;

  // Register index as decoded from paddr[2].
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  localparam logic [2:0] LC_VERT  = 3'd0;
  localparam logic [2:0] LC_HORZ  = 3'd1;
  localparam logic [2:0] LC_SH_UP = 3'd2;
  localparam logic [2:0] LC_ST_UP = 3'd3;
  localparam logic [2:0] LC_SH_DN = 3'd4;
  localparam logic [2:0] LC_ST_DN = 3'd5;

endpackage

FILE: hdl/lr_in_if.sv
// Input channel of the line rasterizer: load and step words.
interface lr_in_if
  import lr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;

  modport source (output valid, op, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, op, start_x, start_y, end_x, end_y, output ready);
endinterface

FILE: hdl/lr_out_if.sv
// Result channel of the line rasterizer: one pixel word per step.
interface lr_out_if
  import lr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic                         visible;
  logic                         last_pixel;

  modport source (output valid, pixel_x, pixel_y, visible, last_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, visible, last_pixel, output ready);
endinterface

FILE: hdl/line_rasterizer.sv
// Top level of the line rasterizer: cursor state, stepping logic and config port.
//
// Usage. Words arrive on in_ch with valid/ready. A word with op = 0 loads a
// line from its two endpoints; it produces no result and replaces any line
// still in progress. A word with op = 1 asks for the next pixel: while a line
// is active it yields one word on out_ch holding the pixel, a visibility flag
// (1..screen_width by 1..screen_height) and a last flag; while idle it is
// consumed and yields nothing. After the last pixel the block goes idle.
//
// Timing. Every accepted word is handled in the cycle it is accepted: setup or
// one Bresenham step is a single add and compare on the cursor and decision
// registers. A pixel appears on out_ch in the cycle after its step word was
// accepted. One word is accepted per cycle while out_ch is not stalled.
//
// Stalls. The output register holds one pixel. in_ch.ready is high while that
// register is empty or being drained this cycle, so a stalled receiver stalls
// the input once a pixel waits in it, and no pixel is ever dropped.
//
// Reset (rst_n low, synchronous) clears the line state to idle and sets the
// screen size to 800 by 600. The APB port writes screen_width at address 0 and
// screen_height at address 4; writes are meant to happen only while idle.
module line_rasterizer
  import lr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  lr_in_if.sink                    in_ch,
  lr_out_if.source                 out_ch,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  // The decision variable swings up to twice the line extent either way.
  localparam int DEC_BITS = COORD_BITS + 4;
  // Width for the clip compare: holds any coordinate and any screen size.
  localparam int CMP_BITS = ((COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS) + 1;

  // Configuration registers.
  logic [DIM_BITS-1:0] width_r, height_r;
  logic                cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_we) begin
      if (paddr[2] == REG_WIDTH) begin
        width_r <= pwdata[DIM_BITS-1:0];
      end else begin
        height_r <= pwdata[DIM_BITS-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_HEIGHT) ? CFG_DATA_BITS'(height_r)
                                           : CFG_DATA_BITS'(width_r);

  // Line state.
  logic signed [COORD_BITS-1:0] cursor_x_r, cursor_y_r, loop_end_r;
  logic signed [COORD_BITS-1:0] cursor_x_nxt, cursor_y_nxt;
  logic signed [DEC_BITS-1:0]   decision_r, step_plain_r, step_move_r, decision_nxt;
  logic [2:0]                   line_case_r;
  logic                         active_r;

  // Setup values for a load word, straight from the input channel.
  logic signed [COORD_BITS-1:0] ld_cursor_x, ld_cursor_y, ld_loop_end;
  logic signed [DEC_BITS-1:0]   ld_decision, ld_step_plain, ld_step_move;
  logic [2:0]                   ld_line_case;

  lr_setup #(
    .COORD_BITS (COORD_BITS),
    .DEC_BITS   (DEC_BITS)
  ) u_setup (
    .x0         (in_ch.start_x),
    .y0         (in_ch.start_y),
    .x1         (in_ch.end_x),
    .y1         (in_ch.end_y),
    .cursor_x   (ld_cursor_x),
    .cursor_y   (ld_cursor_y),
    .loop_end   (ld_loop_end),
    .decision   (ld_decision),
    .step_plain (ld_step_plain),
    .step_move  (ld_step_move),
    .line_case  (ld_line_case)
  );

  // Handshake. The output register is the only buffer between the two sides.
  logic out_valid_r;
  logic in_fire, load_fire, step_fire;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign load_fire   = in_fire && (in_ch.op == OP_LOAD);
  assign step_fire   = in_fire && (in_ch.op == OP_STEP) && active_r;

  // Per-pixel decisions on the current cursor.
  logic                       along_x, last, vis, mv;
  logic signed [CMP_BITS-1:0] cx_e, cy_e, w_e, h_e;

  assign along_x = (line_case_r == LC_HORZ) || (line_case_r == LC_SH_UP) ||
                   (line_case_r == LC_SH_DN);
  assign last    = (along_x ? cursor_x_r : cursor_y_r) >= loop_end_r;

  assign cx_e = CMP_BITS'(cursor_x_r);
  assign cy_e = CMP_BITS'(cursor_y_r);
  assign w_e  = $signed({{(CMP_BITS-DIM_BITS){1'b0}}, width_r});
  assign h_e  = $signed({{(CMP_BITS-DIM_BITS){1'b0}}, height_r});
  assign vis  = (cx_e >= CMP_BITS'(1)) && (cx_e <= w_e) &&
                (cy_e >= CMP_BITS'(1)) && (cy_e <= h_e);

  // Rising cases move on a non-negative decision, falling ones only on positive.
  always_comb begin
    if ((line_case_r == LC_SH_UP) || (line_case_r == LC_ST_UP)) begin
      mv = !decision_r[DEC_BITS-1];
    end else begin
      mv = !decision_r[DEC_BITS-1] && (decision_r != '0);
    end
  end

  always_comb begin
    cursor_x_nxt = cursor_x_r;
    cursor_y_nxt = cursor_y_r;
    decision_nxt = decision_r + (mv ? step_move_r : step_plain_r);
    unique case (line_case_r)
      LC_HORZ: begin
        cursor_x_nxt = cursor_x_r + COORD_BITS'(1);
        decision_nxt = decision_r;
      end
      LC_SH_UP: begin
        cursor_x_nxt = cursor_x_r + COORD_BITS'(1);
        if (mv) cursor_y_nxt = cursor_y_r + COORD_BITS'(1);
      end
      LC_ST_UP: begin
        cursor_y_nxt = cursor_y_r + COORD_BITS'(1);
        if (mv) cursor_x_nxt = cursor_x_r + COORD_BITS'(1);
      end
      LC_SH_DN: begin
        cursor_x_nxt = cursor_x_r + COORD_BITS'(1);
        if (mv) cursor_y_nxt = cursor_y_r - COORD_BITS'(1);
      end
      LC_ST_DN: begin
        cursor_y_nxt = cursor_y_r + COORD_BITS'(1);
        if (mv) cursor_x_nxt = cursor_x_r - COORD_BITS'(1);
      end
      default: begin
        // Vertical, and the unused codes, walk straight up in y.
        cursor_y_nxt = cursor_y_r + COORD_BITS'(1);
        decision_nxt = decision_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r   <= '0;
      cursor_y_r   <= '0;
      loop_end_r   <= '0;
      decision_r   <= '0;
      step_plain_r <= '0;
      step_move_r  <= '0;
      line_case_r  <= LC_VERT;
      active_r     <= 1'b0;
    end else if (load_fire) begin
      cursor_x_r   <= ld_cursor_x;
      cursor_y_r   <= ld_cursor_y;
      loop_end_r   <= ld_loop_end;
      decision_r   <= ld_decision;
      step_plain_r <= ld_step_plain;
      step_move_r  <= ld_step_move;
      line_case_r  <= ld_line_case;
      active_r     <= 1'b1;
    end else if (step_fire) begin
      if (last) begin
        active_r <= 1'b0;
      end else begin
        cursor_x_r <= cursor_x_nxt;
        cursor_y_r <= cursor_y_nxt;
        decision_r <= decision_nxt;
      end
    end
  end

  // Output register.
  logic signed [COORD_BITS-1:0] pixel_x_r, pixel_y_r;
  logic                         visible_r, last_pixel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      pixel_x_r    <= cursor_x_r;
      pixel_y_r    <= cursor_y_r;
      visible_r    <= vis;
      last_pixel_r <= last;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pixel_x    = pixel_x_r;
  assign out_ch.pixel_y    = pixel_y_r;
  assign out_ch.visible    = visible_r;
  assign out_ch.last_pixel = last_pixel_r;

  // A new pixel only appears after a step word taken while a line was active.
  a_pixel_from_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(step_fire))
    else $error("pixel emitted without an accepted step");

  // The final pixel of a line ends it.
  a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    (step_fire && last) |=> !active_r)
    else $error("line still active after its last pixel");

  // A load always starts a line.
  a_load_activates: assert property (@(posedge clk) disable iff (!rst_n)
    load_fire |=> active_r)
    else $error("load did not start a line");

  // A visible pixel never has an x or y coordinate of zero or less.
  a_visible_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && visible_r) |-> (pixel_x_r > 0 && pixel_y_r > 0))
    else $error("visible pixel outside the screen");

endmodule

FILE: hdl/lr_setup.sv
// Line setup: endpoint ordering, line classification and decision start values.
module lr_setup
  import lr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int DEC_BITS   = COORD_BITS + 4
) (
  input  logic signed [COORD_BITS-1:0] x0,
  input  logic signed [COORD_BITS-1:0] y0,
  input  logic signed [COORD_BITS-1:0] x1,
  input  logic signed [COORD_BITS-1:0] y1,
  output logic signed [COORD_BITS-1:0] cursor_x,
  output logic signed [COORD_BITS-1:0] cursor_y,
  output logic signed [COORD_BITS-1:0] loop_end,
  output logic signed [DEC_BITS-1:0]   decision,
  output logic signed [DEC_BITS-1:0]   step_plain,
  output logic signed [DEC_BITS-1:0]   step_move,
  output logic [2:0]                   line_case
);

  logic                         swap;
  logic signed [COORD_BITS-1:0] ax0, ay0, ax1, ay1;
  logic signed [DEC_BITS-1:0]   dx, dy, ady, dx2, ady2;

  assign swap = x1 < x0;
  assign ax0  = swap ? x1 : x0;
  assign ay0  = swap ? y1 : y0;
  assign ax1  = swap ? x0 : x1;
  assign ay1  = swap ? y0 : y1;

  assign dx   = DEC_BITS'(ax1) - DEC_BITS'(ax0);
  assign dy   = DEC_BITS'(ay1) - DEC_BITS'(ay0);
  assign ady  = dy[DEC_BITS-1] ? -dy : dy;
  assign dx2  = dx <<< 1;
  assign ady2 = ady <<< 1;

  always_comb begin
    cursor_x   = ax0;
    cursor_y   = ay0;
    loop_end   = ax1;
    decision   = '0;
    step_plain = '0;
    step_move  = '0;
    priority if (dx == '0) begin
      line_case = LC_VERT;
      cursor_y  = (ay0 < ay1) ? ay0 : ay1;
      loop_end  = (ay0 < ay1) ? ay1 : ay0;
    end else if (dy == '0) begin
      line_case = LC_HORZ;
    end else if (!dy[DEC_BITS-1] && dy <= dx) begin
      line_case  = LC_SH_UP;
      decision   = dy - dx;
      step_plain = dy;
      step_move  = dy - dx;
    end else if (!dy[DEC_BITS-1]) begin
      line_case  = LC_ST_UP;
      loop_end   = ay1;
      decision   = dx - dy;
      step_plain = dx;
      step_move  = dx - dy;
    end else if (ady <= dx) begin
      line_case  = LC_SH_DN;
      decision   = ady2 - dx;
      step_plain = ady2;
      step_move  = ady2 - dx2;
    end else begin
      // Steep falling lines are walked from the endpoint with the smaller y, upward in y with x decreasing.
      line_case  = LC_ST_DN;
      cursor_x   = ax1;
      cursor_y   = ay1;
      loop_end   = ay0;
      decision   = dx2 - ady;
      step_plain = dx2;
      step_move  = dx2 - ady2;
    end
  end

endmodule
